@@ hw/rtl/tcw_pkg.sv @@
// Shared definitions for the text console writer: screen geometry, byte codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELLS      = ROWS * COLUMNS;
    localparam int CELL_W     = 11;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int TAB_SPACES = 5;
    localparam int TABCNT_W   = $clog2(TAB_SPACES + 1);

    typedef logic [CELL_W-1:0]   cell_t;
    typedef logic [COL_W-1:0]    col_t;
    typedef logic [TABCNT_W-1:0] tabcnt_t;

    localparam cell_t   CELLS_C     = cell_t'(CELLS);
    localparam cell_t   COLUMNS_C   = cell_t'(COLUMNS);
    localparam cell_t   LAST_ROW_C  = cell_t'(CELLS - COLUMNS);
    localparam cell_t   COPY_END_C  = cell_t'(CELLS - COLUMNS - 1);
    localparam cell_t   LAST_CELL_C = cell_t'(CELLS - 1);
    localparam col_t    LAST_COL_C  = col_t'(COLUMNS - 1);
    localparam tabcnt_t TAB_DONE_C  = tabcnt_t'(TAB_SPACES);

    // Byte codes
    localparam logic [7:0] SPACE_BYTE  = 8'h20;
    localparam logic [7:0] NL_BYTE     = 8'h0A;
    localparam logic [7:0] TAB_BYTE    = 8'h09;
    localparam logic [7:0] BS_BYTE     = 8'h08;
    localparam logic [7:0] COLOR_RESET = 8'h0F;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CLS_PLAIN,
        CLS_NEWLINE,
        CLS_TAB,
        CLS_BACKSPACE
    } char_class_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_DISPATCH,
        ST_NEWLINE,
        ST_TAB,
        ST_COPY,
        ST_DRAIN,
        ST_FILL,
        ST_CLEAR,
        ST_FINISH
    } ctrl_state_t;

    // Datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT_CELL,
        OP_CLEAR_CELL,
        OP_HOME,
        OP_COPY_CELL,
        OP_FILL_CELL,
        OP_FILL_LAST,
        OP_PUT_CHAR,
        OP_PUT_SPACE,
        OP_BACKSPACE,
        OP_EMIT
    } dp_op_t;

    // Sweep counter control
    typedef enum logic [1:0] {
        SW_HOLD,
        SW_ZERO,
        SW_FILL_BASE,
        SW_INC
    } sweep_op_t;

    typedef struct packed {
        dp_op_t    op;
        sweep_op_t sweep;
    } dp_cmd_t;

    typedef struct packed {
        kind_t       kind;
        char_class_t cls;
        logic        past_end;
        logic        col_last;
        logic        cursor_zero;
        logic        tab_done;
        logic        copy_end;
        logic        sweep_end;
    } dp_status_t;

endpackage

@@ hw/rtl/tcw_ctrl.sv @@
// Controller state machine of the text console writer.
// Depends on tcw_pkg; drives dp_cmd_t commands into tcw_datapath.
module tcw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output tcw_pkg::dp_cmd_t    cmd,
    input  tcw_pkg::dp_status_t status
);
    import tcw_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (status.sweep_end)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                case (status.kind)
                    KIND_WRITE: state_next = ST_DISPATCH;
                    KIND_CLEAR: state_next = ST_CLEAR;
                    default:    state_next = ST_FINISH;
                endcase
            end
            ST_DISPATCH:
            begin
                if (status.past_end)
                    state_next = ST_COPY;
                else
                begin
                    case (status.cls)
                        CLS_NEWLINE: state_next = ST_NEWLINE;
                        CLS_TAB:     state_next = ST_TAB;
                        default:     state_next = ST_FINISH;
                    endcase
                end
            end
            ST_NEWLINE:
            begin
                if (status.col_last)
                    state_next = ST_FINISH;
            end
            ST_TAB:
            begin
                if (status.tab_done)
                    state_next = ST_FINISH;
                else if (status.past_end)
                    state_next = ST_COPY;
            end
            ST_COPY:
            begin
                if (status.copy_end)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                if (status.sweep_end)
                    state_next = ST_DISPATCH;
            end
            ST_CLEAR:
            begin
                if (status.sweep_end)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd.op    = OP_NONE;
        cmd.sweep = SW_HOLD;
        case (state_reg)
            ST_INIT:
            begin
                cmd.op    = OP_INIT_CELL;
                cmd.sweep = SW_INC;
            end
            ST_IDLE:
            begin
                if (start)
                    cmd.op = OP_LOAD;
            end
            ST_DECODE:
            begin
                if (status.kind == KIND_CLEAR)
                begin
                    cmd.op    = OP_HOME;
                    cmd.sweep = SW_ZERO;
                end
            end
            ST_DISPATCH:
            begin
                if (status.past_end)
                    cmd.sweep = SW_ZERO;
                else
                begin
                    case (status.cls)
                        CLS_PLAIN:     cmd.op = OP_PUT_CHAR;
                        CLS_BACKSPACE:
                        begin
                            if (!status.cursor_zero)
                                cmd.op = OP_BACKSPACE;
                        end
                        default:       cmd.op = OP_NONE;
                    endcase
                end
            end
            ST_NEWLINE:
            begin
                cmd.op = OP_PUT_SPACE;
            end
            ST_TAB:
            begin
                if (!status.tab_done)
                begin
                    if (status.past_end)
                        cmd.sweep = SW_ZERO;
                    else
                        cmd.op = OP_PUT_SPACE;
                end
            end
            ST_COPY:
            begin
                cmd.op    = OP_COPY_CELL;
                cmd.sweep = SW_INC;
            end
            ST_DRAIN:
            begin
                cmd.sweep = SW_FILL_BASE;
            end
            ST_FILL:
            begin
                cmd.op    = status.sweep_end ? OP_FILL_LAST : OP_FILL_CELL;
                cmd.sweep = SW_INC;
            end
            ST_CLEAR:
            begin
                cmd.op    = OP_CLEAR_CELL;
                cmd.sweep = SW_INC;
            end
            ST_FINISH:
            begin
                cmd.op = OP_EMIT;
            end
            default:
            begin
                cmd.op    = OP_NONE;
                cmd.sweep = SW_HOLD;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ hw/rtl/tcw_datapath.sv @@
// Datapath of the text console writer: character and attribute memories,
// cursor, sweep counter, item and result registers. Depends on tcw_pkg.
module tcw_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tcw_pkg::dp_cmd_t      cmd,
    output tcw_pkg::dp_status_t   status,
    input  logic [1:0]            kind,
    input  logic [7:0]            character,
    input  logic [7:0]            color,
    input  logic [10:0]           cell_index,
    input  logic                  cfg_write,
    input  logic [7:0]            cfg_data,
    output logic                  done,
    output logic [10:0]           cursor,
    output logic                  scrolled,
    output logic [7:0]            cell_char,
    output logic [7:0]            cell_color
);
    import tcw_pkg::*;

    // Screen memories
    logic [7:0] char_mem [CELLS];
    logic [7:0] attr_mem [CELLS];

    logic [7:0]  default_color_reg;
    cell_t       cursor_reg, cursor_next;
    col_t        col_reg, col_next;
    cell_t       sweep_reg, sweep_next;
    tabcnt_t     tab_cnt_reg, tab_cnt_next;
    logic        scrolled_reg, scrolled_next;
    logic        cp_valid_reg;
    cell_t       cp_addr_reg;
    kind_t       kind_reg;
    logic [7:0]  char_reg;
    logic [7:0]  color_reg;
    cell_t       idx_reg;
    logic [7:0]  rd_char_reg;
    logic [7:0]  rd_attr_reg;
    logic        done_reg, done_next;
    cell_t       out_cursor_reg;
    logic        out_scrolled_reg;
    logic [7:0]  out_char_reg;
    logic [7:0]  out_color_reg;

    char_class_t cls;
    logic        wr_char_en, wr_attr_en;
    cell_t       wr_addr;
    logic [7:0]  wr_char, wr_attr;
    cell_t       rd_addr;
    logic        read_hit;
    col_t        col_inc;
    col_t        col_dec;

    // Classify the latched character
    always_comb
    begin
        case (char_reg)
            NL_BYTE:  cls = CLS_NEWLINE;
            TAB_BYTE: cls = CLS_TAB;
            BS_BYTE:  cls = CLS_BACKSPACE;
            default:  cls = CLS_PLAIN;
        endcase
    end

    assign col_inc = (col_reg == LAST_COL_C) ? '0 : col_reg + col_t'(1);
    assign col_dec = (col_reg == '0) ? LAST_COL_C : col_reg - col_t'(1);

    // Status back to the controller
    always_comb
    begin
        status.kind        = kind_reg;
        status.cls         = cls;
        status.past_end    = (cursor_reg >= CELLS_C);
        status.col_last    = (col_reg == LAST_COL_C);
        status.cursor_zero = (cursor_reg == '0);
        status.tab_done    = (tab_cnt_reg == TAB_DONE_C);
        status.copy_end    = (sweep_reg == COPY_END_C);
        status.sweep_end   = (sweep_reg == LAST_CELL_C);
    end

    // Memory write port; a pending scroll copy owns the port
    always_comb
    begin
        wr_char_en = 1'b0;
        wr_attr_en = 1'b0;
        wr_addr    = sweep_reg;
        wr_char    = SPACE_BYTE;
        wr_attr    = default_color_reg;
        if (cp_valid_reg)
        begin
            wr_char_en = 1'b1;
            wr_attr_en = 1'b1;
            wr_addr    = cp_addr_reg;
            wr_char    = rd_char_reg;
            wr_attr    = rd_attr_reg;
        end
        else
        begin
            case (cmd.op)
                OP_INIT_CELL:
                begin
                    wr_char_en = 1'b1;
                    wr_attr_en = 1'b1;
                    wr_attr    = COLOR_RESET;
                end
                OP_CLEAR_CELL:
                begin
                    wr_char_en = 1'b1;
                end
                OP_FILL_CELL, OP_FILL_LAST:
                begin
                    wr_char_en = 1'b1;
                    wr_attr_en = 1'b1;
                end
                OP_PUT_CHAR:
                begin
                    wr_char_en = 1'b1;
                    wr_attr_en = 1'b1;
                    wr_addr    = cursor_reg;
                    wr_char    = char_reg;
                    wr_attr    = color_reg;
                end
                OP_PUT_SPACE:
                begin
                    wr_char_en = 1'b1;
                    wr_attr_en = 1'b1;
                    wr_addr    = cursor_reg;
                end
                OP_BACKSPACE:
                begin
                    wr_char_en = 1'b1;
                    wr_addr    = cursor_reg - cell_t'(1);
                end
                default:
                begin
                    wr_char_en = 1'b0;
                end
            endcase
        end
    end

    // Read address: scroll source row, else the requested cell
    assign rd_addr = (cmd.op == OP_COPY_CELL) ? sweep_reg + COLUMNS_C : idx_reg;

    always_ff @(posedge clk)
    begin
        if (wr_char_en)
            char_mem[wr_addr] <= wr_char;
        rd_char_reg <= char_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_attr_en)
            attr_mem[wr_addr] <= wr_attr;
        rd_attr_reg <= attr_mem[rd_addr];
    end

    // Cursor, sweep and per-item control next values
    always_comb
    begin
        cursor_next   = cursor_reg;
        col_next      = col_reg;
        tab_cnt_next  = tab_cnt_reg;
        scrolled_next = scrolled_reg;
        done_next     = 1'b0;
        case (cmd.op)
            OP_LOAD:
            begin
                tab_cnt_next  = '0;
                scrolled_next = 1'b0;
            end
            OP_HOME:
            begin
                cursor_next = '0;
                col_next    = '0;
            end
            OP_PUT_CHAR:
            begin
                cursor_next = cursor_reg + cell_t'(1);
                col_next    = col_inc;
            end
            OP_PUT_SPACE:
            begin
                cursor_next = cursor_reg + cell_t'(1);
                col_next    = col_inc;
                if (cls == CLS_TAB)
                    tab_cnt_next = tab_cnt_reg + tabcnt_t'(1);
            end
            OP_BACKSPACE:
            begin
                cursor_next = cursor_reg - cell_t'(1);
                col_next    = col_dec;
            end
            OP_FILL_LAST:
            begin
                cursor_next   = LAST_ROW_C;
                col_next      = '0;
                scrolled_next = 1'b1;
            end
            OP_EMIT:
            begin
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.sweep)
            SW_ZERO:      sweep_next = '0;
            SW_FILL_BASE: sweep_next = LAST_ROW_C;
            SW_INC:       sweep_next = sweep_reg + cell_t'(1);
            default:      sweep_next = sweep_reg;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_color_reg <= COLOR_RESET;
            cursor_reg        <= '0;
            col_reg           <= '0;
            sweep_reg         <= '0;
            tab_cnt_reg       <= '0;
            scrolled_reg      <= 1'b0;
            cp_valid_reg      <= 1'b0;
            kind_reg          <= KIND_NOP;
            done_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                default_color_reg <= cfg_data;
            cursor_reg   <= cursor_next;
            col_reg      <= col_next;
            sweep_reg    <= sweep_next;
            tab_cnt_reg  <= tab_cnt_next;
            scrolled_reg <= scrolled_next;
            cp_valid_reg <= (cmd.op == OP_COPY_CELL);
            if (cmd.op == OP_LOAD)
                kind_reg <= kind_t'(kind);
            done_reg     <= done_next;
        end
    end

    // Item and result payload registers
    assign read_hit = (kind_reg == KIND_READ) && (idx_reg < CELLS_C);

    always_ff @(posedge clk)
    begin
        cp_addr_reg <= sweep_reg;
        if (cmd.op == OP_LOAD)
        begin
            char_reg  <= character;
            color_reg <= color;
            idx_reg   <= cell_index;
        end
        if (cmd.op == OP_EMIT)
        begin
            out_cursor_reg   <= cursor_reg;
            out_scrolled_reg <= scrolled_reg;
            out_char_reg     <= read_hit ? rd_char_reg : 8'h00;
            out_color_reg    <= read_hit ? rd_attr_reg : 8'h00;
        end
    end

    assign done       = done_reg;
    assign cursor     = out_cursor_reg;
    assign scrolled   = out_scrolled_reg;
    assign cell_char  = out_char_reg;
    assign cell_color = out_color_reg;

    // Checks
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");
    assert property (@(posedge clk) disable iff (!rst_n) cursor_reg <= CELLS_C)
        else $error("cursor beyond one past the last cell");
    assert property (@(posedge clk) disable iff (!rst_n) col_reg <= LAST_COL_C)
        else $error("column out of range");
    // copy and idle commands write nothing, so only they may overlap a copy write
    assert property (@(posedge clk) disable iff (!rst_n)
                     cp_valid_reg |-> (cmd.op == OP_NONE || cmd.op == OP_COPY_CELL))
        else $error("write port collision with scroll copy");
    assert property (@(posedge clk) disable iff (!rst_n) tab_cnt_reg <= TAB_DONE_C)
        else $error("tab space count overran");
    assert property (@(posedge clk) disable iff (!rst_n)
                     cmd.op == OP_FILL_LAST |=> cursor_reg == LAST_ROW_C && scrolled_reg)
        else $error("scroll did not park the cursor on the last row");

endmodule

@@ hw/rtl/text_console_writer_top.sv @@
// Item flow: busy stays high from the taken start until the result is strobed on done, so
// the next item is taken only after busy drops. A newline writes one space per cell up to the
// end of the row (up to 80 cells), a tab writes 5; a scroll, also inside a tab, runs through
// one memory port pair: 1920 cell copies, a drain step, 80 fills and a redispatch;
// clear blanks the character of every cell.
// Reset: busy stays high for a pass that sets all 2000 cells to a space with color 15.
// Results are strobed for one cycle on done and cannot be stalled.
module text_console_writer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [7:0]  character,
    input  logic [7:0]  color,
    input  logic [10:0] cell_index,
    input  logic        cfg_write,
    input  logic [7:0]  cfg_data,
    output logic        done,
    output logic [10:0] cursor,
    output logic        scrolled,
    output logic [7:0]  cell_char,
    output logic [7:0]  cell_color
);
    import tcw_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    tcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    tcw_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .kind       (kind),
        .character  (character),
        .color      (color),
        .cell_index (cell_index),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .done       (done),
        .cursor     (cursor),
        .scrolled   (scrolled),
        .cell_char  (cell_char),
        .cell_color (cell_color)
    );

endmodule

@@ dv/text_console_writer_top_tb.sv @@
// Self-checking testbench for text_console_writer_top: drives write, clear, read and no-op
// items and checks every result against a shadow screen kept inside the bench.
// Depends on tcw_pkg (geometry, byte codes, kind_t) and the text_console_writer_top RTL.
module text_console_writer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    // Cycles with no item taken and no result strobed before the run is called hung; the
    // longest quiet spells are a scroll plus a full-row newline, a clear and the power-on pass.
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        cell_t      cursor;
        logic       scrolled;
        logic [7:0] cell_char;
        logic [7:0] cell_color;
    } console_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  kind = '0;
    logic [7:0]  character = '0;
    logic [7:0]  color = '0;
    logic [10:0] cell_index = '0;
    logic        cfg_write = 1'b0;
    logic [7:0]  cfg_data = '0;
    logic        done;
    logic [10:0] cursor;
    logic        scrolled;
    logic [7:0]  cell_char;
    logic [7:0]  cell_color;

    // Shadow copy of the screen, cursor and default color
    logic [7:0] shadow_char [CELLS];
    logic [7:0] shadow_attr [CELLS];
    int         shadow_cursor;
    logic [7:0] shadow_color;
    logic       shadow_scrolled;

    console_result_t results_due[$];
    int              fail_count;
    int              idle_pct;
    int              quiet_cycles;

    text_console_writer_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .character  (character),
        .color      (color),
        .cell_index (cell_index),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .done       (done),
        .cursor     (cursor),
        .scrolled   (scrolled),
        .cell_char  (cell_char),
        .cell_color (cell_color)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Screen model
    function automatic void scroll_screen();
        for (int i = 0; i < CELLS - COLUMNS; i++)
        begin
            shadow_char[i] = shadow_char[i + COLUMNS];
            shadow_attr[i] = shadow_attr[i + COLUMNS];
        end
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
        begin
            shadow_char[i] = SPACE_BYTE;
            shadow_attr[i] = shadow_color;
        end
        shadow_cursor   = CELLS - COLUMNS;
        shadow_scrolled = 1'b1;
    endfunction

    function automatic void put_cell(logic [7:0] ch, logic [7:0] attr);
        if (shadow_cursor >= CELLS)
            scroll_screen();
        shadow_char[shadow_cursor] = ch;
        shadow_attr[shadow_cursor] = attr;
        shadow_cursor++;
    endfunction

    function automatic console_result_t apply_console_item(kind_t k, logic [7:0] ch,
                                                           logic [7:0] attr, cell_t idx);
        console_result_t r;
        r = '0;
        shadow_scrolled = 1'b0;
        case (k)
            KIND_WRITE:
            begin
                if (shadow_cursor >= CELLS)
                    scroll_screen();
                if (ch == NL_BYTE)
                begin
                    do
                        put_cell(SPACE_BYTE, shadow_color);
                    while (shadow_cursor % COLUMNS != 0);
                end
                else if (ch == TAB_BYTE)
                begin
                    for (int i = 0; i < TAB_SPACES; i++)
                        put_cell(SPACE_BYTE, shadow_color);
                end
                else if (ch == BS_BYTE)
                begin
                    // only the character byte is blanked
                    if (shadow_cursor > 0)
                    begin
                        shadow_cursor--;
                        shadow_char[shadow_cursor] = SPACE_BYTE;
                    end
                end
                else
                    put_cell(ch, attr);
            end
            KIND_CLEAR:
            begin
                foreach (shadow_char[i])
                    shadow_char[i] = SPACE_BYTE;
                shadow_cursor = 0;
            end
            KIND_READ:
            begin
                if (idx < CELLS)
                begin
                    r.cell_char  = shadow_char[idx];
                    r.cell_color = shadow_attr[idx];
                end
            end
            default: ;
        endcase
        r.cursor   = cell_t'(shadow_cursor);
        r.scrolled = shadow_scrolled;
        return r;
    endfunction

    // Send one item; called and returns right after a rising edge
    task automatic send_item(kind_t k, logic [7:0] ch, logic [7:0] attr, cell_t idx);
        int gap;
        gap = 0;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            gap = $urandom_range(1, 4);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        kind       <= k;
        character  <= ch;
        color      <= attr;
        cell_index <= idx;
        do
            @(posedge clk);
        while (busy);
        results_due.push_back(apply_console_item(k, ch, attr, idx));
    endtask

    // Hold off until every result is back and the block is idle
    task automatic drain_console();
        start <= 1'b0;
        while (results_due.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_default_color(logic [7:0] value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        shadow_color = value;
    endtask

    // Result checker
    always @(posedge clk)
    begin : check_results
        console_result_t want;
        if (rst_n && done)
        begin
            if (results_due.size() == 0)
            begin
                $error("result arrived with none expected");
                fail_count++;
            end
            else
            begin
                want = results_due.pop_front();
                if (cursor !== want.cursor)
                begin
                    $error("cursor: expected %0d, got %0d", want.cursor, cursor);
                    fail_count++;
                end
                if (scrolled !== want.scrolled)
                begin
                    $error("scrolled: expected %0d, got %0d", want.scrolled, scrolled);
                    fail_count++;
                end
                if (cell_char !== want.cell_char)
                begin
                    $error("cell_char: expected %0h, got %0h", want.cell_char, cell_char);
                    fail_count++;
                end
                if (cell_color !== want.cell_color)
                begin
                    $error("cell_color: expected %0h, got %0h", want.cell_color, cell_color);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("text_console_writer_top_tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Power-on screen: reads at both ends, out of range, and a no-op
    task automatic test_power_on_screen();
        send_item(KIND_READ, 8'h00, 8'h00, cell_t'(0));
        send_item(KIND_READ, 8'hFF, 8'hFF, cell_t'(CELLS - 1));
        send_item(KIND_READ, 8'h00, 8'h00, cell_t'(CELLS));
        send_item(KIND_READ, 8'hFF, 8'hFF, 11'h7FF);
        send_item(KIND_NOP, 8'hFF, 8'hFF, 11'h7FF);
    endtask

    // Extreme character and color bytes, read back
    task automatic test_plain_chars();
        send_item(KIND_WRITE, 8'h00, 8'h00, cell_t'(0));
        send_item(KIND_WRITE, 8'hFF, 8'hFF, cell_t'(0));
        send_item(KIND_READ, 8'h00, 8'h00, cell_t'(0));
        send_item(KIND_READ, 8'h00, 8'h00, cell_t'(1));
    endtask

    // Clear, backspace at home, tab, backspace, newline mid-row and at column zero
    task automatic test_control_chars();
        drain_console();
        set_default_color(8'hA5);
        send_item(KIND_CLEAR, 8'h41, 8'h00, cell_t'(0));
        send_item(KIND_WRITE, BS_BYTE, 8'h00, cell_t'(0));
        send_item(KIND_WRITE, 8'h48, 8'h1E, cell_t'(0));
        send_item(KIND_WRITE, TAB_BYTE, 8'h00, cell_t'(0));
        send_item(KIND_WRITE, BS_BYTE, 8'h00, cell_t'(0));
        send_item(KIND_WRITE, NL_BYTE, 8'h00, cell_t'(0));
        send_item(KIND_WRITE, NL_BYTE, 8'h00, cell_t'(0));
        send_item(KIND_READ, 8'h00, 8'h00, cell_t'(0));
        send_item(KIND_READ, 8'h00, 8'h00, cell_t'(5));
        send_item(KIND_READ, 8'h00, 8'h00, cell_t'(COLUMNS + 3));
    endtask

    // Fill to past the end, rest there, then scroll; clear while past the end
    task automatic test_scroll();
        drain_console();
        set_default_color(8'hFF);
        while (shadow_cursor < CELLS)
            send_item(KIND_WRITE, NL_BYTE, 8'h00, cell_t'(0));
        send_item(KIND_READ, 8'h00, 8'h00, cell_t'(CELLS - 1));
        send_item(KIND_NOP, 8'h00, 8'h00, cell_t'(0));
        send_item(KIND_WRITE, 8'h5A, 8'h3C, cell_t'(0));
        send_item(KIND_READ, 8'h00, 8'h00, cell_t'(CELLS - COLUMNS));
        send_item(KIND_READ, 8'h00, 8'h00, cell_t'(CELLS - COLUMNS + 1));
        send_item(KIND_READ, 8'h00, 8'h00, cell_t'(COLUMNS));
        send_item(KIND_WRITE, NL_BYTE, 8'h00, cell_t'(0));
        send_item(KIND_WRITE, TAB_BYTE, 8'h00, cell_t'(0));
        send_item(KIND_WRITE, NL_BYTE, 8'h00, cell_t'(0));
        send_item(KIND_CLEAR, 8'h00, 8'h00, cell_t'(0));
    endtask

    // Mostly writes with random content; newlines push the cursor to the bottom
    task automatic test_random_traffic();
        kind_t      k;
        logic [7:0] ch;
        cell_t      idx;
        int         pick;
        for (int p = 0; p < 4; p++)
        begin
            drain_console();
            case (p)
                0: set_default_color(8'h00);
                2: set_default_color(8'hFF);
                default: set_default_color(8'($urandom_range(0, 255)));
            endcase
            case (p)
                1: idle_pct = 67;
                2: idle_pct = 22;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < 210; n++)
            begin
                pick = $urandom_range(0, 199);
                ch   = 8'($urandom_range(0, 255));
                idx  = cell_t'($urandom_range(0, 2047));
                if (pick == 0)
                    k = KIND_CLEAR;
                else if (pick < 7)
                    k = KIND_NOP;
                else if (pick < 37)
                begin
                    k = KIND_READ;
                    case ($urandom_range(0, 9))
                        0: idx = cell_t'($urandom_range(CELLS, 2047));
                        1, 2, 3, 4:
                            idx = cell_t'((shadow_cursor + CELLS - $urandom_range(1, 8)) % CELLS);
                        default: idx = cell_t'($urandom_range(0, CELLS - 1));
                    endcase
                end
                else
                begin
                    k = KIND_WRITE;
                    case ($urandom_range(0, 24))
                        0, 1, 2, 3, 4: ch = NL_BYTE;
                        5, 6: ch = TAB_BYTE;
                        7, 8: ch = BS_BYTE;
                        default: ;
                    endcase
                end
                send_item(k, ch, 8'($urandom_range(0, 255)), idx);
            end
        end
    endtask

    initial
    begin
        fail_count   = 0;
        idle_pct     = 0;
        quiet_cycles = 0;
        shadow_color = COLOR_RESET;
        shadow_cursor = 0;
        foreach (shadow_char[i])
        begin
            shadow_char[i] = SPACE_BYTE;
            shadow_attr[i] = COLOR_RESET;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_power_on_screen();
        test_plain_chars();
        test_control_chars();
        test_scroll();
        test_random_traffic();

        drain_console();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && results_due.size() == 0)
            $display("text_console_writer_top_tb passed");
        else
            $display("text_console_writer_top_tb failed");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/tcw_datapath.sv
hw/rtl/text_console_writer_top.sv
dv/text_console_writer_top_tb.sv
